FILE: rtl/bihc_pkg.sv
// ----------------------------------------------------------------------------
// bihc_pkg
// Shared types, constants and the byte-wide crc-32 update for the boot image
// header check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bihc_pkg;

  // default length of the image name field in bytes
  localparam int NAME_BYTES_DEF = 32;

  // fixed part of the header in front of the name field
  localparam int FIXED_BYTES = 32;

  // expected big-endian magic word
  localparam logic [31:0] HDR_MAGIC = 32'h2705_1956;

  // reflected crc-32 polynomial
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // result status codes
  localparam int STATUS_W = 3;
  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SHORT = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MAGIC = 3'd2;
  localparam logic [STATUS_W-1:0] ST_CRC   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BIG   = 3'd4;

  // register indexes on the configuration port
  localparam logic REG_IMAGE_LENGTH   = 1'b0;
  localparam logic REG_PARTITION_SIZE = 1'b1;

  // configuration handed from the register file to the core
  typedef struct packed {
    logic [31:0] image_length;
    logic [31:0] partition_size;
  } cfg_t;

  // one byte through the reflected crc-32, lsb first
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc,
                                             input logic [7:0]  data);
    logic [31:0] c;
    c = crc ^ {24'h00_0000, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: rtl/bihc_if.sv
// ----------------------------------------------------------------------------
// bihc_if
// Valid/ready channels for header bytes in and check status out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bihc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] hdr_byte;
  logic       frame_start;

  modport source (output valid, output hdr_byte, output frame_start, input ready);
  modport sink   (input valid, input hdr_byte, input frame_start, output ready);
  modport mon    (input valid, input hdr_byte, input frame_start, input ready);
endinterface

interface bihc_out_if import bihc_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                header_ok;

  modport source (output valid, output status, output header_ok, input ready);
  modport sink   (input valid, input status, input header_ok, output ready);
  modport mon    (input valid, input status, input header_ok, input ready);
endinterface

FILE: rtl/bihc_core.sv
// ----------------------------------------------------------------------------
// bihc_core
// Input register, header state with byte-wide crc-32 update, status logic
// and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bihc_core import bihc_pkg::*; #(
  parameter int NAME_BYTES = NAME_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  cfg_t           cfg,
  bihc_in_if.sink        in_chan,
  bihc_out_if.source     out_chan
);

  localparam int HEADER_BYTES = FIXED_BYTES + NAME_BYTES;
  localparam int CNT_W        = $clog2(HEADER_BYTES + 1);

  localparam logic [CNT_W-1:0] CNT_MAGIC_END = CNT_W'(4);
  localparam logic [CNT_W-1:0] CNT_CRC_END   = CNT_W'(8);
  localparam logic [CNT_W-1:0] CNT_LAST      = CNT_W'(HEADER_BYTES);

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_start_r;

  // header state
  logic [CNT_W-1:0] cnt_r,    cnt_nxt;
  logic [31:0]      magic_r,  magic_nxt;
  logic [31:0]      stored_r, stored_nxt;
  logic [31:0]      crc_r,    crc_nxt;
  logic             done_r,   done_nxt;

  // output register
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r, status_nxt;
  logic                out_ok_r;

  // state as seen by the held byte after an optional restart
  logic [CNT_W-1:0] eff_cnt;
  logic [31:0]      eff_magic;
  logic [31:0]      eff_stored;
  logic [31:0]      eff_crc;
  logic             eff_done;

  logic       active;
  logic       emit;
  logic       out_free;
  logic       s1_go;
  logic [7:0] fed;
  logic [CNT_W-1:0] cnt_inc;

  // restart applies before the byte is taken
  always_comb begin
    eff_cnt    = s1_start_r ? '0       : cnt_r;
    eff_magic  = s1_start_r ? '0       : magic_r;
    eff_stored = s1_start_r ? '0       : stored_r;
    eff_crc    = s1_start_r ? CRC_INIT : crc_r;
    eff_done   = s1_start_r ? 1'b0     : done_r;
  end

  // byte update: magic field, stored crc field fed as zero, crc, counter
  always_comb begin
    active     = !eff_done;
    cnt_inc    = eff_cnt + CNT_W'(1);
    magic_nxt  = eff_magic;
    stored_nxt = eff_stored;
    fed        = s1_byte_r;
    if (eff_cnt < CNT_MAGIC_END) begin
      magic_nxt = {eff_magic[23:0], s1_byte_r};
    end else if (eff_cnt < CNT_CRC_END) begin
      stored_nxt = {eff_stored[23:0], s1_byte_r};
      fed        = 8'h00;
    end
    crc_nxt  = crc32_byte(eff_crc, fed);
    cnt_nxt  = cnt_inc;
    emit     = active && (cnt_inc == CNT_LAST);
    done_nxt = eff_done | emit;
    if (!active) begin
      magic_nxt  = eff_magic;
      stored_nxt = eff_stored;
      crc_nxt    = eff_crc;
      cnt_nxt    = eff_cnt;
    end
  end

  // checks in priority order on the last header byte
  always_comb begin
    if (cfg.image_length < 32'(HEADER_BYTES)) begin
      status_nxt = ST_SHORT;
    end else if (eff_magic != HDR_MAGIC) begin
      status_nxt = ST_MAGIC;
    end else if ((crc_nxt ^ CRC_INIT) != eff_stored) begin
      status_nxt = ST_CRC;
    end else if (cfg.image_length > cfg.partition_size) begin
      status_nxt = ST_BIG;
    end else begin
      status_nxt = ST_OK;
    end
  end

  // flow control: held byte moves unless its result has nowhere to go
  assign out_free       = !out_valid_r || out_chan.ready;
  assign s1_go          = s1_valid_r && (!emit || out_free);
  assign in_chan.ready  = !s1_valid_r || s1_go;

  // input register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_byte_r  <= in_chan.hdr_byte;
      s1_start_r <= in_chan.frame_start;
    end
  end

  // header state, reset equals a freshly started frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      magic_r  <= '0;
      stored_r <= '0;
      crc_r    <= CRC_INIT;
      done_r   <= 1'b0;
    end else if (s1_go) begin
      cnt_r    <= cnt_nxt;
      magic_r  <= magic_nxt;
      stored_r <= stored_nxt;
      crc_r    <= crc_nxt;
      done_r   <= done_nxt;
    end
  end

  // output register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (s1_go && emit) begin
      out_status_r <= status_nxt;
      out_ok_r     <= (status_nxt == ST_OK);
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.status    = out_status_r;
  assign out_chan.header_ok = out_ok_r;

endmodule

FILE: rtl/boot_image_header_check_top.sv
// ----------------------------------------------------------------------------
// boot_image_header_check_top
// Boot image header check: crc-32 and field checks over a streamed header,
// with an apb-style register port for image length and partition size.
// ----------------------------------------------------------------------------
// status path: the last byte of a header is accepted into the input register,
// then the crc/status stage writes its status into the output register
// throughput: one header byte per cycle, set by the single byte-wide crc update;
// only a last byte waits for a stalled status, bytes that give no result do not
// reset: synchronous active-low rst_n clears the channels, starts a new frame
// and sets both registers to zero
`timescale 1ns / 1ps

module boot_image_header_check_top import bihc_pkg::*; #(
  parameter int NAME_BYTES = NAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  bihc_in_if.sink     in_chan,
  bihc_out_if.source  out_chan,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_t cfg_r;
  logic cfg_wr;
  logic reg_sel;

  assign cfg_pready = 1'b1;
  assign reg_sel    = cfg_paddr[2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // register writes in the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_IMAGE_LENGTH:   cfg_r.image_length   <= cfg_pwdata;
        REG_PARTITION_SIZE: cfg_r.partition_size <= cfg_pwdata;
        default:            cfg_r                <= cfg_r;
      endcase
    end
  end

  // register read-back
  always_comb begin
    case (reg_sel)
      REG_IMAGE_LENGTH:   cfg_prdata = cfg_r.image_length;
      REG_PARTITION_SIZE: cfg_prdata = cfg_r.partition_size;
      default:            cfg_prdata = '0;
    endcase
  end

  bihc_core #(
    .NAME_BYTES (NAME_BYTES)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

endmodule

FILE: rtl/bihc_checker.sv
// ----------------------------------------------------------------------------
// bihc_checker
// Port-level checks on the status channel of the boot image header check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bihc_checker import bihc_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] out_status,
  input logic                out_header_ok
);

  // a stalled status transaction keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_status) && $stable(out_header_ok)))
    else $error("status transaction changed while stalled");

  // header_ok agrees with the status code
  a_ok_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_header_ok == (out_status == ST_OK)))
    else $error("header_ok does not match status");

  // only defined status codes are delivered
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_SHORT ||
                   out_status == ST_MAGIC || out_status == ST_CRC ||
                   out_status == ST_BIG))
    else $error("undefined status code");

  // reset empties both channels' pipeline registers
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && in_ready))
    else $error("pipeline not cleared by reset");

endmodule

bind boot_image_header_check_top bihc_checker u_bihc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_status    (out_chan.status),
  .out_header_ok (out_chan.header_ok)
);

FILE: test/tb_boot_image_header_check_top.sv
// ----------------------------------------------------------------------------
// tb_boot_image_header_check_top
// Self-checking bench for the boot image header check. Headers are streamed
// in over the byte channel while an in-bench model tracks magic, stored crc
// and the running crc-32, and predicts every status. Statuses are compared
// field by field in arrival order. Register settings change between phases
// through the apb-style port, with a read-back of each write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_boot_image_header_check_top;
  import bihc_pkg::*;

  localparam int HEADER_BYTES  = FIXED_BYTES + NAME_BYTES_DEF;
  localparam int PIPE_LAT      = 2;
  localparam int SETTLE_CYCLES = PIPE_LAT + 4;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int TARGET_ITEMS  = 1850;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                header_ok;
  } status_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  bihc_in_if  in_chan ();
  bihc_out_if out_chan ();

  boot_image_header_check_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // model copy of the registers and the header state
  logic [31:0] img_len_q;
  logic [31:0] part_size_q;
  logic [6:0]  hdr_count;
  logic [31:0] hdr_magic;
  logic [31:0] hdr_stored_crc;
  logic [31:0] hdr_crc;
  logic        hdr_done;

  status_t     expected_status_q [$];
  int          err_count;
  int          taken_count;
  bit          no_idle;
  logic [7:0]  hdr_buf [HEADER_BYTES];

  // clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  // reflected crc-32, one byte lsb first
  function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = {1'b0, c[31:1]} ^ (c[0] ? CRC_POLY : 32'h0);
    end
    return c;
  endfunction

  function automatic void restart_header();
    hdr_count      = '0;
    hdr_magic      = '0;
    hdr_stored_crc = '0;
    hdr_crc        = CRC_INIT;
    hdr_done       = 1'b0;
  endfunction

  // model of one accepted byte; pushes a status on the last header byte
  function automatic void predict_byte(input logic [7:0] b, input logic fs);
    logic [7:0] fed;
    status_t    st;
    fed = b;
    if (fs) restart_header();
    if (hdr_done) return;
    taken_count++;
    if (hdr_count < 4) begin
      hdr_magic = {hdr_magic[23:0], b};
    end else if (hdr_count < 8) begin
      hdr_stored_crc = {hdr_stored_crc[23:0], b};
      fed = 8'h00;
    end
    hdr_crc   = crc_step(hdr_crc, fed);
    hdr_count = hdr_count + 7'd1;
    if (hdr_count < HEADER_BYTES) return;
    hdr_done = 1'b1;
    if (img_len_q < HEADER_BYTES) st.status = ST_SHORT;
    else if (hdr_magic != HDR_MAGIC) st.status = ST_MAGIC;
    else if (~hdr_crc != hdr_stored_crc) st.status = ST_CRC;
    else if (img_len_q > part_size_q) st.status = ST_BIG;
    else st.status = ST_OK;
    st.header_ok = (st.status == ST_OK);
    expected_status_q.push_back(st);
  endfunction

  // input monitor: every accepted byte transaction goes through the model
  always @(posedge clk) begin
    if (rst_n && in_chan.valid && in_chan.ready) predict_byte(in_chan.hdr_byte,
                                                              in_chan.frame_start);
  end

  // status checker
  always @(posedge clk) begin
    status_t exp_st;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_status_q.size() == 0) begin
        report_mismatch($sformatf("unexpected status %0d", out_chan.status));
      end else begin
        exp_st = expected_status_q.pop_front();
        if (out_chan.status !== exp_st.status)
          report_mismatch($sformatf("status %0d, expected %0d", out_chan.status,
                                    exp_st.status));
        if (out_chan.header_ok !== exp_st.header_ok)
          report_mismatch($sformatf("header_ok %0b, expected %0b", out_chan.header_ok,
                                    exp_st.header_ok));
      end
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    out_chan.ready <= no_idle || ($urandom_range(0, 99) >= 20);
  end

  // one byte transaction, with an occasional gap in front
  task automatic send_byte(input logic [7:0] b, input logic fs);
    if (!no_idle && $urandom_range(0, 99) < 20) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.hdr_byte    <= b;
    in_chan.frame_start <= fs;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  // stop sending and wait until every predicted status has come out
  task automatic wait_results_drained();
    int waited;
    waited = 0;
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (expected_status_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write followed by a read-back
  task automatic cfg_write(input logic reg_sel, input logic [31:0] value);
    logic [31:0] rd;
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {reg_sel, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (reg_sel == REG_IMAGE_LENGTH) img_len_q = value;
    else part_size_q = value;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rd = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (rd !== value)
      report_mismatch($sformatf("register %0d read %h, wrote %h", reg_sel, rd, value));
  endtask

  task automatic set_regs(input logic [31:0] img_len, input logic [31:0] part_size);
    cfg_write(REG_IMAGE_LENGTH, img_len);
    cfg_write(REG_PARTITION_SIZE, part_size);
  endtask

  // fill hdr_buf with a header of random content
  function automatic void build_header(input bit good_magic, input bit good_crc);
    logic [31:0] magic;
    logic [31:0] crc;
    for (int i = 0; i < HEADER_BYTES; i++) hdr_buf[i] = 8'($urandom_range(0, 255));
    if (good_magic) magic = HDR_MAGIC;
    else if ($urandom_range(0, 1) == 0) magic = HDR_MAGIC ^ (32'h1 << $urandom_range(0, 31));
    else magic = $urandom;
    if (!good_magic && magic == HDR_MAGIC) magic = ~HDR_MAGIC;
    for (int i = 0; i < 4; i++) begin
      hdr_buf[i]     = magic[31-8*i -: 8];
      hdr_buf[4 + i] = 8'h00;
    end
    crc = CRC_INIT;
    for (int i = 0; i < HEADER_BYTES; i++) crc = crc_step(crc, hdr_buf[i]);
    crc = ~crc;
    if (!good_crc) begin
      if ($urandom_range(0, 1) == 0) crc = crc ^ (32'h1 << $urandom_range(0, 31));
      else crc = crc ^ ($urandom | 32'h1);
    end
    for (int i = 0; i < 4; i++) hdr_buf[4 + i] = crc[31-8*i -: 8];
  endfunction

  // send the first n bytes of hdr_buf, start mark on byte 0 if asked
  task automatic send_header(input bit with_start, input int n);
    for (int i = 0; i < n; i++) send_byte(hdr_buf[i], (i == 0) && with_start);
  endtask

  // reset state is a started frame: no start mark needed, bytes after are ignored
  task automatic test_no_start_after_reset();
    set_regs(HEADER_BYTES, 32'hFFFF_FFFF);
    build_header(1'b1, 1'b1);
    send_header(1'b0, HEADER_BYTES);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    wait_results_drained();
  endtask

  // each status code, with the registers at their extremes
  task automatic test_status_codes();
    set_regs(HEADER_BYTES - 1, 32'hFFFF_FFFF);
    build_header(1'b1, 1'b1);
    send_header(1'b1, HEADER_BYTES);
    wait_results_drained();
    set_regs(32'h0, 32'h0);
    build_header(1'b0, 1'b0);
    send_header(1'b1, HEADER_BYTES);
    wait_results_drained();
    set_regs(HEADER_BYTES, HEADER_BYTES);
    build_header(1'b0, 1'b1);
    send_header(1'b1, HEADER_BYTES);
    build_header(1'b1, 1'b0);
    send_header(1'b1, HEADER_BYTES);
    build_header(1'b1, 1'b1);
    send_header(1'b1, HEADER_BYTES);
    wait_results_drained();
    set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFE);
    build_header(1'b1, 1'b1);
    send_header(1'b1, HEADER_BYTES);
    wait_results_drained();
    set_regs(HEADER_BYTES, 32'h0);
    build_header(1'b1, 1'b1);
    send_header(1'b1, HEADER_BYTES);
    wait_results_drained();
  endtask

  // start mark in the middle of a header throws the partial header away
  task automatic test_restart();
    set_regs(HEADER_BYTES, 32'hFFFF_FFFF);
    build_header(1'b1, 1'b1);
    send_header(1'b1, 30);
    build_header(1'b1, 1'b1);
    send_header(1'b1, HEADER_BYTES - 1);
    build_header(1'b1, 1'b1);
    send_header(1'b1, HEADER_BYTES);
    wait_results_drained();
  endtask

  // mostly well-formed headers, with truncated ones and loose bytes between
  task automatic test_random_stream();
    int          phase;
    int          kind;
    int          n;
    logic [31:0] img_len;
    logic [31:0] part_size;
    phase = 0;
    while (taken_count < TARGET_ITEMS) begin
      // new register setting every eight phases, after the statuses drain
      if (phase % 8 == 0) begin
        wait_results_drained();
        case ($urandom_range(0, 5))
          0:       img_len = 32'h0;
          1:       img_len = HEADER_BYTES - 1;
          2:       img_len = HEADER_BYTES;
          3:       img_len = 32'hFFFF_FFFF;
          default: img_len = $urandom_range(HEADER_BYTES, 32'h00FF_FFFF);
        endcase
        case ($urandom_range(0, 5))
          0:       part_size = img_len;
          1:       part_size = img_len - 1;
          2:       part_size = 32'hFFFF_FFFF;
          3:       part_size = 32'h0;
          default: part_size = $urandom;
        endcase
        set_regs(img_len, part_size);
      end
      // phases 10 to 17 run with no gaps on either side, but for the register change at phase 16
      no_idle = (phase >= 10 && phase < 18);
      // sender holds off until every status has arrived
      if (phase == 21) wait_results_drained();
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        build_header($urandom_range(0, 99) < 85, $urandom_range(0, 99) < 85);
        send_header($urandom_range(0, 99) < 95, HEADER_BYTES);
        if ($urandom_range(0, 99) < 30) begin
          repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
      end else if (kind < 85) begin
        build_header(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        send_header(1'b1, $urandom_range(1, HEADER_BYTES - 1));
      end else begin
        n = $urandom_range(1, 8);
        repeat (n) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 99) < 10);
      end
      phase++;
    end
    no_idle = 1'b0;
  endtask

  // main sequence
  initial begin
    rst_n               = 1'b0;
    cfg_psel            = 1'b0;
    cfg_penable         = 1'b0;
    cfg_pwrite          = 1'b0;
    cfg_paddr           = '0;
    cfg_pwdata          = '0;
    in_chan.valid       = 1'b0;
    in_chan.hdr_byte    = '0;
    in_chan.frame_start = 1'b0;
    out_chan.ready      = 1'b0;
    no_idle             = 1'b0;
    err_count           = 0;
    taken_count         = 0;
    img_len_q           = '0;
    part_size_q         = '0;
    restart_header();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_no_start_after_reset();
    test_status_codes();
    test_restart();
    test_random_stream();

    wait_results_drained();
    if (expected_status_q.size() != 0)
      report_mismatch($sformatf("%0d statuses never arrived", expected_status_q.size()));
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
